/* hdl/i2c_target_edge_fsm_defines.svh */
// assertion macros shared by the i2c target checker
`ifndef I2C_TARGET_EDGE_FSM_DEFINES_SVH
`define I2C_TARGET_EDGE_FSM_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define I2C_TE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c target check failed");

// next-cycle implication, disabled while reset is low
`define I2C_TE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c target check failed");

`endif

/* hdl/i2c_te_pkg.sv */
// types and constants of the i2c target edge controller
package i2c_te_pkg;

    localparam int BUFFER_BYTES = 8;
    localparam int RX_IDX_W     = $clog2(BUFFER_BYTES + 1);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_ACK    = 3'd3,
        PH_ACKING = 3'd4,
        PH_NACK   = 3'd5,
        PH_END    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        FN_SCL_FALL = 3'd0,
        FN_SCL_RISE = 3'd1,
        FN_SDA_FALL = 3'd2,
        FN_SDA_RISE = 3'd3,
        FN_TICK     = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        CFG_ADDR  = 2'd0,
        CFG_SEND  = 2'd1,
        CFG_RLEN  = 2'd2,
        CFG_TICKS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       sda_drive;
        logic       sda_value;
        logic [2:0] phase;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [3:0] byte_index;
        logic       frame_complete;
        logic       addressed;
        logic       read_mode;
        logic       timed_out;
    } t_result;

endpackage

/* hdl/i2c_target_edge_fsm.sv */
// i2c target controller driven by pin-edge and tick events
// an accepted event's result appears on the output register in the next cycle
// throughput: one event per cycle; input is taken while a result waits if it is drained
// the single state update per event sits between the state registers and the result register
// reset: synchronous active-low; idle phase, sda released, timeout limit 100 ticks
// configuration registers are written through the write port
module i2c_target_edge_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic        i_sda_level,
    input  logic        i_scl_level,
    input  logic        i_ack_allowed,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_sda_drive,
    output logic        o_sda_value,
    output logic [2:0]  o_phase,
    output logic        o_byte_valid,
    output logic [7:0]  o_byte_value,
    output logic [3:0]  o_byte_index,
    output logic        o_frame_complete,
    output logic        o_addressed,
    output logic        o_read_mode,
    output logic        o_timed_out,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic                w_in_ready;
    logic                w_fire;
    i2c_te_pkg::t_result w_core_res;
    i2c_te_pkg::t_result w_out_res;

    // a transaction on the event channel updates state and loads the result register
    assign w_fire  = i_valid && w_in_ready;
    assign o_ready = w_in_ready;

    // per-event state machine, config registers and timeout counter
    i2c_te_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_func        (i_func),
        .i_sda_level   (i_sda_level),
        .i_scl_level   (i_scl_level),
        .i_ack_allowed (i_ack_allowed),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_result      (w_core_res)
    );

    // result register decouples the two handshakes
    i2c_te_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_result   (w_core_res),
        .o_in_ready (w_in_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (w_out_res)
    );

    // unpack the result onto individual ports
    assign o_sda_drive      = w_out_res.sda_drive;
    assign o_sda_value      = w_out_res.sda_value;
    assign o_phase          = w_out_res.phase;
    assign o_byte_valid     = w_out_res.byte_valid;
    assign o_byte_value     = w_out_res.byte_value;
    assign o_byte_index     = w_out_res.byte_index;
    assign o_frame_complete = w_out_res.frame_complete;
    assign o_addressed      = w_out_res.addressed;
    assign o_read_mode      = w_out_res.read_mode;
    assign o_timed_out      = w_out_res.timed_out;

endmodule

/* hdl/i2c_te_core.sv */
// protocol state, configuration registers and per-event update logic
module i2c_te_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [2:0]          i_func,
    input  logic                i_sda_level,
    input  logic                i_scl_level,
    input  logic                i_ack_allowed,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    output i2c_te_pkg::t_result o_result
);

    localparam int RXW = i2c_te_pkg::RX_IDX_W;

    // configuration
    logic [6:0]  r_addr;
    logic [63:0] r_send;
    logic [2:0]  r_rlen;
    logic [15:0] r_tticks;

    // transaction state
    i2c_te_pkg::t_phase r_phase, n_phase;
    logic [3:0]     r_bit_cnt, n_bit_cnt;
    logic [7:0]     r_shift, n_shift;
    logic [RXW-1:0] r_rx_idx, n_rx_idx;
    logic [2:0]     r_tx_idx, n_tx_idx;
    logic           r_read, n_read;
    logic           r_match, n_match;
    logic [15:0]    r_tcount, n_tcount;
    logic           r_trun, n_trun;
    logic           r_drive, n_drive;
    logic           r_level, n_level;

    // per-event helpers
    logic [7:0]     w_tx_byte;
    logic [7:0]     w_sb_new;
    logic [3:0]     w_bc_inc;
    logic           w_byte_done;
    logic           w_addr_ok;
    logic           w_addr_byte;
    logic [RXW-1:0] w_rx_inc;
    logic [15:0]    w_tc_inc;
    logic           w_expire;
    logic           w_cfg_clear;

    logic           n_bvalid;
    logic [7:0]     n_bvalue;
    logic [3:0]     n_bindex;
    logic           n_fdone;
    logic           n_tout;

    assign w_tx_byte   = r_send[{r_tx_idx, 3'b000} +: 8];
    assign w_sb_new    = r_shift | ((i_sda_level && !r_bit_cnt[3])
                                    ? (8'h80 >> r_bit_cnt[2:0]) : 8'h00);
    assign w_bc_inc    = r_bit_cnt + 4'd1;
    assign w_byte_done = w_bc_inc[3];
    assign w_addr_ok   = (w_sb_new[7:1] == r_addr) && i_ack_allowed;
    assign w_addr_byte = (r_rx_idx == '0);
    assign w_rx_inc    = r_rx_idx + RXW'(1);
    assign w_tc_inc    = r_trun ? (r_tcount + 16'd1) : r_tcount;
    assign w_expire    = (w_tc_inc >= r_tticks);
    assign w_cfg_clear = i_cfg_we &&
                         (i2c_te_pkg::t_cfg_idx'(i_cfg_index) == i2c_te_pkg::CFG_ADDR);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            case (i2c_te_pkg::t_func'(i_func))
                i2c_te_pkg::FN_SCL_FALL: begin
                    unique case (r_phase)
                        i2c_te_pkg::PH_START:  n_phase = i2c_te_pkg::PH_DATA;
                        i2c_te_pkg::PH_DATA: begin
                            if (r_read && w_byte_done) begin
                                n_phase = i2c_te_pkg::PH_ACK;
                            end
                        end
                        i2c_te_pkg::PH_ACK:    n_phase = i2c_te_pkg::PH_ACKING;
                        i2c_te_pkg::PH_ACKING: n_phase = i2c_te_pkg::PH_DATA;
                        i2c_te_pkg::PH_NACK:   n_phase = i2c_te_pkg::PH_END;
                        i2c_te_pkg::PH_END:    n_phase = i2c_te_pkg::PH_IDLE;
                        default:               n_phase = r_phase;
                    endcase
                end
                i2c_te_pkg::FN_SCL_RISE: begin
                    unique case (r_phase)
                        i2c_te_pkg::PH_DATA: begin
                            if (!r_read && w_byte_done) begin
                                n_phase = (w_addr_byte && !w_addr_ok)
                                          ? i2c_te_pkg::PH_NACK : i2c_te_pkg::PH_ACK;
                            end
                        end
                        i2c_te_pkg::PH_ACK: begin
                            n_phase = (r_read && i_sda_level)
                                      ? i2c_te_pkg::PH_NACK : i2c_te_pkg::PH_ACKING;
                        end
                        i2c_te_pkg::PH_END: n_phase = i2c_te_pkg::PH_IDLE;
                        default:            n_phase = r_phase;
                    endcase
                end
                i2c_te_pkg::FN_SDA_FALL: begin
                    if (i_scl_level && r_phase == i2c_te_pkg::PH_IDLE) begin
                        n_phase = i2c_te_pkg::PH_START;
                    end
                end
                i2c_te_pkg::FN_SDA_RISE: begin
                    if (i_scl_level) begin
                        n_phase = i2c_te_pkg::PH_IDLE;
                    end
                end
                i2c_te_pkg::FN_TICK: begin
                    if (w_expire) begin
                        n_phase = i2c_te_pkg::PH_IDLE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // datapath, flags and per-event report
    always_comb begin
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_rx_idx  = r_rx_idx;
        n_tx_idx  = r_tx_idx;
        n_read    = r_read;
        n_match   = r_match;
        n_tcount  = r_tcount;
        n_trun    = r_trun;
        n_drive   = r_drive;
        n_level   = r_level;
        n_bvalid  = 1'b0;
        n_bvalue  = 8'h00;
        n_bindex  = 4'd0;
        n_fdone   = 1'b0;
        n_tout    = 1'b0;
        if (w_cfg_clear) begin
            n_bit_cnt = 4'd0;
            n_shift   = 8'h00;
            n_rx_idx  = '0;
            n_tx_idx  = 3'd0;
            n_read    = 1'b0;
            n_match   = 1'b0;
            n_drive   = 1'b0;
        end else if (i_fire) begin
            case (i2c_te_pkg::t_func'(i_func))
                i2c_te_pkg::FN_SCL_FALL: begin
                    unique case (r_phase)
                        i2c_te_pkg::PH_START: n_drive = 1'b0;
                        i2c_te_pkg::PH_DATA: begin
                            if (r_read) begin
                                if (!w_byte_done) begin
                                    n_bit_cnt = w_bc_inc;
                                    n_level   = w_tx_byte[3'd7 - w_bc_inc[2:0]];
                                end else begin
                                    n_drive   = 1'b0;
                                    n_tx_idx  = r_tx_idx + 3'd1;
                                    n_bit_cnt = 4'd0;
                                end
                            end
                        end
                        i2c_te_pkg::PH_ACK: begin
                            n_level = 1'b0;
                            n_drive = 1'b1;
                        end
                        i2c_te_pkg::PH_ACKING: begin
                            if (r_read) begin
                                n_drive = 1'b1;
                                n_level = w_tx_byte[7];
                            end else begin
                                n_drive = 1'b0;
                            end
                        end
                        i2c_te_pkg::PH_NACK: n_drive = 1'b0;
                        default: n_drive = r_drive;
                    endcase
                end
                i2c_te_pkg::FN_SCL_RISE: begin
                    if (r_phase == i2c_te_pkg::PH_DATA && !r_read) begin
                        n_bit_cnt = w_bc_inc;
                        n_shift   = w_sb_new;
                        if (w_byte_done) begin
                            n_bit_cnt = 4'd0;
                            if (w_addr_byte && !w_addr_ok) begin
                                // refused address keeps the shifted byte
                                n_match = 1'b0;
                            end else begin
                                if (w_addr_byte) begin
                                    n_match = 1'b1;
                                    n_read  = w_sb_new[0];
                                end
                                // bytes past the buffer are acked but dropped
                                if (r_rx_idx < RXW'(i2c_te_pkg::BUFFER_BYTES)) begin
                                    n_bvalid = 1'b1;
                                    n_bvalue = w_sb_new;
                                    n_bindex = 4'(r_rx_idx);
                                    n_rx_idx = w_rx_inc;
                                    n_fdone  = (5'(w_rx_inc) == (5'(r_rlen) + 5'd1));
                                end
                                n_shift = 8'h00;
                            end
                        end
                    end
                end
                i2c_te_pkg::FN_SDA_FALL: begin
                    if (i_scl_level && r_phase == i2c_te_pkg::PH_IDLE) begin
                        n_bit_cnt = 4'd0;
                        n_shift   = 8'h00;
                        n_rx_idx  = '0;
                        n_tx_idx  = 3'd0;
                        n_read    = 1'b0;
                        n_match   = 1'b0;
                        n_drive   = 1'b0;
                        n_tcount  = 16'd0;
                        n_trun    = 1'b1;
                    end
                end
                i2c_te_pkg::FN_SDA_RISE: begin
                    if (i_scl_level) begin
                        n_tcount = 16'd0;
                        n_trun   = 1'b0;
                    end
                end
                i2c_te_pkg::FN_TICK: begin
                    n_tcount = w_tc_inc;
                    // a stopped timer still fires when the limit is already reached
                    if (w_expire) begin
                        n_tcount = 16'd0;
                        n_trun   = 1'b0;
                        n_drive  = 1'b0;
                        n_tout   = 1'b1;
                    end
                end
                default: n_tout = 1'b0;
            endcase
        end
    end

    assign o_result.sda_drive      = n_drive;
    assign o_result.sda_value      = n_drive ? n_level : 1'b1;
    assign o_result.phase          = n_phase;
    assign o_result.byte_valid     = n_bvalid;
    assign o_result.byte_value     = n_bvalue;
    assign o_result.byte_index     = n_bindex;
    assign o_result.frame_complete = n_fdone;
    assign o_result.addressed      = n_match;
    assign o_result.read_mode      = n_read;
    assign o_result.timed_out      = n_tout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= 7'd0;
            r_send   <= 64'd0;
            r_rlen   <= 3'd0;
            r_tticks <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i2c_te_pkg::t_cfg_idx'(i_cfg_index))
                i2c_te_pkg::CFG_ADDR:  r_addr   <= i_cfg_data[7:1];
                i2c_te_pkg::CFG_SEND:  r_send   <= i_cfg_data;
                i2c_te_pkg::CFG_RLEN:  r_rlen   <= i_cfg_data[2:0];
                i2c_te_pkg::CFG_TICKS: r_tticks <= i_cfg_data[15:0];
                default:               r_addr   <= r_addr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2c_te_pkg::PH_IDLE;
            r_bit_cnt <= 4'd0;
            r_shift   <= 8'h00;
            r_rx_idx  <= '0;
            r_tx_idx  <= 3'd0;
            r_read    <= 1'b0;
            r_match   <= 1'b0;
            r_tcount  <= 16'd0;
            r_trun    <= 1'b0;
            r_drive   <= 1'b0;
            r_level   <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_rx_idx  <= n_rx_idx;
            r_tx_idx  <= n_tx_idx;
            r_read    <= n_read;
            r_match   <= n_match;
            r_tcount  <= n_tcount;
            r_trun    <= n_trun;
            r_drive   <= n_drive;
            r_level   <= n_level;
        end
    end

endmodule

/* hdl/i2c_te_outreg.sv */
// result register with valid/ready handshake towards the consumer
module i2c_te_outreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2c_te_pkg::t_result i_result,
    output logic                o_in_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output i2c_te_pkg::t_result o_result
);

    logic                r_valid, n_valid;
    i2c_te_pkg::t_result r_result;

    // free when empty or being drained this cycle
    assign o_in_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hdl/i2c_te_checker.sv */
// port-level checks for the i2c target controller, bound to the top level
`include "i2c_target_edge_fsm_defines.svh"

module i2c_te_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_sda_drive,
    input logic       o_sda_value,
    input logic [2:0] o_phase,
    input logic       o_byte_valid,
    input logic [7:0] o_byte_value,
    input logic [3:0] o_byte_index,
    input logic       o_frame_complete,
    input logic       o_addressed,
    input logic       o_timed_out
);

    // stalled result holds
    `I2C_TE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_phase) && $stable(o_byte_value) && $stable(o_sda_drive))

    // released line always reads high
    `I2C_TE_ASSERT_IMPL(a_release_high, i_clk, i_rst_n, o_valid && !o_sda_drive, o_sda_value)

    // a reported address byte implies a match
    `I2C_TE_ASSERT_IMPL(a_addr_match, i_clk, i_rst_n, o_valid && o_byte_valid && o_byte_index == 4'd0, o_addressed)

    // timeout leaves the bus idle and released
    `I2C_TE_ASSERT_IMPL(a_timeout_idle, i_clk, i_rst_n, o_valid && o_timed_out, o_phase == i2c_te_pkg::PH_IDLE && !o_sda_drive)

    // frame completion comes with a stored byte
    `I2C_TE_ASSERT_IMPL(a_frame_byte, i_clk, i_rst_n, o_valid && o_frame_complete, o_byte_valid)

endmodule

bind i2c_target_edge_fsm i2c_te_checker u_i2c_te_checker (.*);
